// ===== rtl/qfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qfa_pkg;

  localparam int FRAC_BITS   = 6;
  localparam int MUL_SHIFT_A = 2;
  localparam int MUL_SHIFT_B = 4;
  localparam int WORD_W      = 16;
  localparam int DSR_W       = 16;
  localparam int DVD_W       = DSR_W + FRAC_BITS;
  localparam int DIV_STEPS   = DVD_W;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_EQ    = 3'd4;
  localparam logic [2:0] OP_TOINT = 3'd5;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     equal_flag;
    logic                     divide_by_zero;
  } out_t;

  typedef struct packed {
    logic [DSR_W-1:0] rem;
    logic [DVD_W-1:0] work;
    logic [DSR_W-1:0] dsr;
  } div_t;

  typedef struct packed {
    logic is_div;
    logic neg;
    out_t fast;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/qfa_pre.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qfa_pre (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  qfa_pkg::in_t  in_item,
  output logic          out_valid,
  output qfa_pkg::div_t out_div,
  output qfa_pkg::side_t out_side
);
  import qfa_pkg::*;

  logic                     valid_r;
  div_t                     div_r, div_nxt;
  side_t                    side_r, side_nxt;
  logic signed [WORD_W:0]   a_ext, b_ext;
  logic [WORD_W:0]          a_abs, b_abs;
  logic signed [WORD_W-MUL_SHIFT_A-1:0] mul_a;
  logic signed [WORD_W-MUL_SHIFT_B-1:0] mul_b;
  logic signed [2*WORD_W-MUL_SHIFT_A-MUL_SHIFT_B-1:0] prod;

  always_comb begin
    a_ext = {in_item.operand_a[WORD_W-1], in_item.operand_a};
    b_ext = {in_item.operand_b[WORD_W-1], in_item.operand_b};
    a_abs = a_ext[WORD_W] ? (~a_ext + 1'b1) : a_ext;
    b_abs = b_ext[WORD_W] ? (~b_ext + 1'b1) : b_ext;
    mul_a = in_item.operand_a[WORD_W-1:MUL_SHIFT_A];
    mul_b = in_item.operand_b[WORD_W-1:MUL_SHIFT_B];
    prod  = mul_a * mul_b;

    div_nxt.rem  = '0;
    div_nxt.work = {a_abs[DSR_W-1:0], {FRAC_BITS{1'b0}}};
    div_nxt.dsr  = b_abs[DSR_W-1:0];

    side_nxt.is_div = 1'b0;
    side_nxt.neg    = in_item.operand_a[WORD_W-1] ^ in_item.operand_b[WORD_W-1];
    side_nxt.fast   = '0;
    unique case (in_item.operation)
      OP_ADD: side_nxt.fast.result_value = in_item.operand_a + in_item.operand_b;
      OP_SUB: side_nxt.fast.result_value = in_item.operand_a - in_item.operand_b;
      OP_MUL: side_nxt.fast.result_value = prod[WORD_W-1:0];
      OP_DIV: begin
        side_nxt.is_div              = (in_item.operand_b != '0);
        side_nxt.fast.divide_by_zero = (in_item.operand_b == '0);
      end
      OP_EQ: side_nxt.fast.equal_flag = (in_item.operand_a == in_item.operand_b);
      OP_TOINT: side_nxt.fast.result_value = in_item.operand_a >>> FRAC_BITS;
      default: side_nxt.fast = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    div_r  <= div_nxt;
    side_r <= side_nxt;
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// ===== rtl/qfa_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qfa_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  qfa_pkg::div_t  in_div,
  input  qfa_pkg::side_t in_side,
  output logic           out_valid,
  output qfa_pkg::div_t  out_div,
  output qfa_pkg::side_t out_side
);
  import qfa_pkg::*;

  logic             valid_r;
  div_t             div_r, div_nxt;
  side_t            side_r;
  logic [DSR_W:0]   partial, trial;
  logic             fits;

  always_comb begin
    partial = {in_div.rem, in_div.work[DVD_W-1]};
    trial   = partial - {1'b0, in_div.dsr};
    fits    = (partial >= {1'b0, in_div.dsr});
    div_nxt.rem  = fits ? trial[DSR_W-1:0] : partial[DSR_W-1:0];
    div_nxt.work = {in_div.work[DVD_W-2:0], fits};
    div_nxt.dsr  = in_div.dsr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    div_r  <= div_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// ===== rtl/qfa_post.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qfa_post (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  qfa_pkg::div_t  in_div,
  input  qfa_pkg::side_t in_side,
  output logic           out_valid,
  output qfa_pkg::out_t  out_result
);
  import qfa_pkg::*;

  logic              valid_r;
  out_t              result_r, result_nxt;
  logic [WORD_W-1:0] quot;

  always_comb begin
    quot       = in_div.work[WORD_W-1:0];
    result_nxt = in_side.fast;
    if (in_side.is_div) begin
      result_nxt.result_value = in_side.neg ? (~quot + 1'b1) : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

// ===== rtl/q10_6_fixed_point_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake         Payload
// input     start, busy       in_data    (operation, operand_a, operand_b)
// result    out_valid strobe  out_result (result_value, equal_flag, divide_by_zero)
//
// One item is taken every cycle while busy is low; each result passes the pre, divider and post registers.
// The restoring divider produces one quotient bit per stage over 22 stages.
// Synchronous reset empties the pipeline and holds busy high until reset is released.
// The receiver cannot stall, so the pipeline always advances and busy stays low once out of reset.

module q10_6_fixed_point_alu (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  qfa_pkg::in_t  in_data,
  output logic          out_valid,
  output qfa_pkg::out_t out_result
);
  import qfa_pkg::*;

  logic  busy_r;
  logic  accept;
  logic  stg_valid [DIV_STEPS+1];
  div_t  stg_div   [DIV_STEPS+1];
  side_t stg_side  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  qfa_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_data),
    .out_valid (stg_valid[0]),
    .out_div   (stg_div[0]),
    .out_side  (stg_side[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    qfa_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[i]),
      .in_div    (stg_div[i]),
      .in_side   (stg_side[i]),
      .out_valid (stg_valid[i+1]),
      .out_div   (stg_div[i+1]),
      .out_side  (stg_side[i+1])
    );
  end

  qfa_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stg_valid[DIV_STEPS]),
    .in_div     (stg_div[DIV_STEPS]),
    .in_side    (stg_side[DIV_STEPS]),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_result.equal_flag && out_result.divide_by_zero))
    else $error("Both flags are set on one result.");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.divide_by_zero |-> out_result.result_value == '0)
    else $error("A zero divisor gave a nonzero result.");

  a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.equal_flag |-> out_result.result_value == '0)
    else $error("A compare gave a nonzero result.");

  a_busy_low: assert property (@(posedge clk)
    rst_n |=> !busy)
    else $error("Busy is high outside reset.");

  a_no_output_after_reset: assert property (@(posedge clk)
    !rst_n |=> !stg_valid[0])
    else $error("A transfer entered the pipeline during reset.");

endmodule

`default_nettype wire

// ===== bench/q10_6_fixed_point_alu_checker.sv =====
`timescale 1ns / 1ps

module q10_6_fixed_point_alu_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  qfa_pkg::in_t  in_data,
  input  logic          out_valid,
  input  qfa_pkg::out_t out_result,
  input  logic          run_done,
  output int            errors,
  output int            results_seen
);
  import qfa_pkg::*;

  out_t pending_results[$];
  logic leftovers_counted;

  function automatic out_t q10_6_result(in_t item);
    out_t r;
    int   a;
    int   b;
    int   prod;
    int   quot;
    r = '0;
    a = item.operand_a;
    b = item.operand_b;
    case (item.operation)
      OP_ADD: begin
        r.result_value = 16'(a + b);
      end
      OP_SUB: begin
        r.result_value = 16'(a - b);
      end
      OP_MUL: begin
        prod = (a >>> MUL_SHIFT_A) * (b >>> MUL_SHIFT_B);
        r.result_value = prod[15:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          quot = (a * (1 << FRAC_BITS)) / b;
          r.result_value = quot[15:0];
        end
      end
      OP_EQ: begin
        r.equal_flag = (a == b);
      end
      OP_TOINT: begin
        r.result_value = 16'(a >>> FRAC_BITS);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    int   err_add;
    err_add = 0;
    if (!rst_n) begin
      pending_results.delete();
      errors <= 0;
      results_seen <= 0;
      leftovers_counted <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_results.push_back(q10_6_result(in_data));
      end
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d eq=%0b dz=%0b", $time,
                   out_result.result_value, out_result.equal_flag,
                   out_result.divide_by_zero);
          err_add = err_add + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_result !== want) begin
            $display("%0t: mismatch expected value=%0d eq=%0b dz=%0b,",
                     $time, want.result_value, want.equal_flag, want.divide_by_zero);
            $display("    actual value=%0d eq=%0b dz=%0b",
                     out_result.result_value, out_result.equal_flag,
                     out_result.divide_by_zero);
            err_add = err_add + 1;
          end
        end
      end
      if (run_done && !leftovers_counted) begin
        leftovers_counted <= 1'b1;
        if (pending_results.size() != 0) begin
          $display("%0t: %0d expected results never arrived", $time,
                   pending_results.size());
          err_add = err_add + pending_results.size();
        end
      end
      if (err_add != 0) begin
        errors <= errors + err_add;
      end
    end
  end

endmodule

// ===== bench/q10_6_fixed_point_alu_tb.sv =====
`timescale 1ns / 1ps

module q10_6_fixed_point_alu_tb;
  import qfa_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_result;
  logic run_done;
  int   errors;
  int   results_seen;
  int   transfers_sent;
  int   quiet_cycles;

  q10_6_fixed_point_alu dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  q10_6_fixed_point_alu_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_result  (out_result),
    .run_done    (run_done),
    .errors      (errors),
    .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [15:0] a, input logic [15:0] b,
                         input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data.operation <= op;
    in_data.operand_a <= a;
    in_data.operand_b <= b;
    do @(posedge clk); while (busy);
    transfers_sent++;
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, 1023)) - 16'd512;
      5: return 16'($urandom_range(0, 63)) << 6;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count, input int idle_pct);
    logic [2:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      a = pick_operand();
      b = pick_operand();
      if (op == OP_EQ && $urandom_range(0, 1)) begin
        b = a;
      end
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        b = 16'h0000;
      end
      send_op(op, a, b, idle_pct);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    run_done = 1'b0;
    transfers_sent = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_op(OP_ADD, 16'h7FFF, 16'h0001, 0);
    send_op(OP_ADD, 16'h8000, 16'hFFFF, 0);
    send_op(OP_ADD, 16'h1234, 16'h0040, 0);
    send_op(OP_SUB, 16'h8000, 16'h0001, 0);
    send_op(OP_SUB, 16'h7FFF, 16'h8000, 0);
    send_op(OP_MUL, 16'h8000, 16'h8000, 0);
    send_op(OP_MUL, 16'h7FFF, 16'h7FFF, 0);
    send_op(OP_MUL, 16'hFFFF, 16'hFFFF, 0);
    send_op(OP_MUL, 16'h0100, 16'hFFC0, 0);
    send_op(OP_DIV, 16'h0040, 16'h0000, 0);
    send_op(OP_DIV, 16'h8000, 16'hFFFF, 0);
    send_op(OP_DIV, 16'hFFFF, 16'h0003, 0);
    send_op(OP_DIV, 16'h7FFF, 16'h0001, 0);
    send_op(OP_DIV, 16'h0000, 16'h8000, 0);
    send_op(OP_EQ, 16'h8000, 16'h8000, 0);
    send_op(OP_EQ, 16'h7FFF, 16'h7FFE, 0);
    send_op(OP_TOINT, 16'hFFFF, 16'h7FFF, 0);
    send_op(OP_TOINT, 16'h7FFF, 16'h0000, 0);
    send_op(OP_TOINT, 16'h8000, 16'hFFFF, 0);
    send_op(OP_SPARE_6, 16'h7FFF, 16'h7FFF, 0);
    send_op(OP_SPARE_7, 16'h8000, 16'h8000, 0);

    send_random(500, 0);
    send_random(400, 82);
    send_random(500, 22);
    send_random(350, 0);
    start <= 1'b0;

    while (results_seen < transfers_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered all six operations plus the spare codes,");
    $display("operand extremes and zero divisors.");
    $display("%0d transfers sent under four pacing phases, %0d results checked.",
             transfers_sent, results_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
